>>> src/sem_pkg.sv
package sem_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int WIDTH_W = 11;
   localparam int HEIGHT_W = 16;
   localparam int EMIT_W = 26;
   localparam int TOTAL_W = WIDTH_W + HEIGHT_W;
   localparam int PADDR_W = 3;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

   localparam logic REG_IMAGE_WIDTH = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef logic [23:0] pix_type;
   typedef logic [8:0][23:0] nbhd_type;
   typedef logic [8:0][7:0] chan_nbhd_type;

   typedef struct packed {
      logic kind;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic run_last;
      logic frame_end;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic pix_read;
      logic pix_update;
      logic take_next;
      logic drain_addr;
      logic drain_data;
      logic drain_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic ignore;
      logic is_drain;
      logic pending;
      logic mag_busy;
      logic out_free;
      logic drain_last;
   } status_type;

endpackage

>>> src/sem_ram.sv
module sem_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH = 1024
) (
   input  logic clock,
   input  logic we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> src/sem_mag.sv
module sem_mag (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  sem_pkg::chan_nbhd_type nb,
   output logic busy,
   output logic [7:0] mag
);
   import sem_pkg::*;

   logic signed [10:0] gx_ff, gy_ff, gx_in, gy_in;
   logic [10:0] xpos, xneg, ypos, yneg;
   logic [20:0] s_ff, s_in;
   logic signed [21:0] sqx, sqy;
   logic [7:0] n_ff, n_in, t;
   logic [15:0] tt;
   logic [16:0] nn;
   logic [2:0] k;
   logic [3:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic [7:0] mag_ff, mag_in;

   always_comb begin
      xpos = {3'b0, nb[2]} + {2'b0, nb[5], 1'b0} + {3'b0, nb[8]};
      xneg = {3'b0, nb[0]} + {2'b0, nb[3], 1'b0} + {3'b0, nb[6]};
      ypos = {3'b0, nb[6]} + {2'b0, nb[7], 1'b0} + {3'b0, nb[8]};
      yneg = {3'b0, nb[0]} + {2'b0, nb[1], 1'b0} + {3'b0, nb[2]};
      gx_in = $signed(xpos - xneg);
      gy_in = $signed(ypos - yneg);
      sqx = gx_ff * gx_ff;
      sqy = gy_ff * gy_ff;
      k = 3'(4'd8 - step_ff);
      t = n_ff | (8'd1 << k);
      tt = {8'b0, t} * {8'b0, t};
      nn = {9'b0, n_ff} * {9'b0, n_ff} + {9'b0, n_ff};
      s_in = s_ff;
      n_in = n_ff;
      mag_in = mag_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         step_in = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 4'd1;
         if (step_ff == 4'd0) begin
            s_in = 21'(sqx) + 21'(sqy);
            n_in = 8'd0;
         end else if (step_ff <= 4'd8) begin
            if ({5'b0, tt} <= s_ff) begin
               n_in = t;
            end
         end else begin
            busy_in = 1'b0;
            if (s_ff > 21'd65280) begin
               mag_in = 8'd255;
            end else if (s_ff > {4'b0, nn} && n_ff != 8'd255) begin
               mag_in = n_ff + 8'd1;
            end else begin
               mag_in = n_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      if (start) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      s_ff <= s_in;
      n_ff <= n_in;
      mag_ff <= mag_in;
   end

   assign busy = busy_ff;
   assign mag = mag_ff;
endmodule

>>> src/sem_datapath.sv
module sem_datapath #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  sem_pkg::cmd_type cmd,
   output sem_pkg::status_type status,
   input  logic cfg_write,
   input  logic [sem_pkg::WIDTH_W-1:0] cfg_width,
   input  logic [sem_pkg::HEIGHT_W-1:0] cfg_height,
   input  sem_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output sem_pkg::rsp_type rsp_data
);
   import sem_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int CMPW = (CW >= WIDTH_W) ? CW + 1 : WIDTH_W + 1;

   logic [CMPW-1:0] eff_w, col_ext, col_next, didx_ext;
   logic [HEIGHT_W-1:0] eff_h;
   logic [TOTAL_W-1:0] total_ff;

   logic kind_ff;
   pix_type px_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [EMIT_W-1:0] emit_ff, emit_in;
   nbhd_type win_ff, win_in, shifted, dnb_ff, nb_sel;
   logic a_ff, b_ff, last_ff, dok_ff, dok_in;
   logic [1:0] didx_ff;
   logic [CW-1:0] raddr, dx;
   pix_type up_rd, mid_rd, col0, col1;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic mag_go, restart;
   logic [2:0] busy_v;
   logic [2:0][7:0] mags;
   logic frame_end;

   always_comb begin
      if (cfg_width == '0) begin
         eff_w = CMPW'(1);
      end else if (CMPW'(cfg_width) > CMPW'(MAX_WIDTH)) begin
         eff_w = CMPW'(MAX_WIDTH);
      end else begin
         eff_w = CMPW'(cfg_width);
      end
      eff_h = (cfg_height == '0) ? HEIGHT_W'(1) : cfg_height;
   end

   assign col_ext = CMPW'(col_ff);
   assign col_next = col_ext + CMPW'(1);
   assign didx_ext = col_ext + CMPW'(didx_ff);

   always_comb begin
      dok_in = (didx_ext >= CMPW'(1)) && (didx_ext - CMPW'(1) < eff_w);
      dx = dok_in ? CW'(didx_ext - CMPW'(1)) : '0;
      raddr = cmd.drain_addr ? dx : col_ff;
      col0 = (row_ff >= HEIGHT_W'(2)) ? up_rd : '0;
      col1 = (row_ff >= HEIGHT_W'(1)) ? mid_rd : '0;
      for (int i = 0; i < 3; i++) begin
         win_in[i*3] = (col_ff == '0) ? '0 : win_ff[i*3+1];
         win_in[i*3+1] = (col_ff == '0) ? '0 : win_ff[i*3+2];
         shifted[i*3] = win_ff[i*3+1];
         shifted[i*3+1] = win_ff[i*3+2];
         shifted[i*3+2] = '0;
      end
      win_in[2] = col0;
      win_in[5] = col1;
      win_in[8] = px_ff;
      if (cmd.take_next) begin
         nb_sel = a_ff ? win_ff : shifted;
      end else begin
         nb_sel = dnb_ff;
      end
   end

   assign mag_go = cmd.take_next | cmd.drain_start;
   assign frame_end = ({1'b0, emit_ff} == total_ff - TOTAL_W'(1));
   assign restart = cfg_write | (cmd.out_load && kind_ff == KIND_DRAIN && col_next >= eff_w);

   sem_ram #(.DATA_W(24), .DEPTH(MAX_WIDTH)) u_upper (
      .clock(clock), .we(cmd.pix_update), .waddr(col_ff), .wdata(mid_rd),
      .raddr(raddr), .rdata(up_rd)
   );

   sem_ram #(.DATA_W(24), .DEPTH(MAX_WIDTH)) u_middle (
      .clock(clock), .we(cmd.pix_update), .waddr(col_ff), .wdata(px_ff),
      .raddr(raddr), .rdata(mid_rd)
   );

   for (genvar ch = 0; ch < 3; ch++) begin : g_mag
      chan_nbhd_type cnb;
      always_comb begin
         for (int i = 0; i < 9; i++) begin
            cnb[i] = nb_sel[i][(2-ch)*8 +: 8];
         end
      end
      sem_mag u_mag (
         .clock(clock), .reset(reset), .start(mag_go), .nb(cnb),
         .busy(busy_v[ch]), .mag(mags[ch])
      );
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      emit_in = emit_ff;
      if (cmd.pix_update) begin
         if (col_next >= eff_w) begin
            col_in = '0;
            row_in = row_ff + HEIGHT_W'(1);
         end else begin
            col_in = CW'(col_next);
         end
      end
      if (cmd.out_load) begin
         emit_in = emit_ff + EMIT_W'(1);
         if (kind_ff == KIND_DRAIN) begin
            col_in = CW'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         emit_ff <= '0;
         win_ff <= '0;
         a_ff <= 1'b0;
         b_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (restart) begin
            col_ff <= '0;
            row_ff <= '0;
            emit_ff <= '0;
            win_ff <= '0;
         end else begin
            col_ff <= col_in;
            row_ff <= row_in;
            emit_ff <= emit_in;
            if (cmd.pix_update) begin
               win_ff <= win_in;
            end
         end
         if (cmd.pix_update) begin
            a_ff <= (row_ff >= HEIGHT_W'(1)) && (col_ff != '0);
            b_ff <= (row_ff >= HEIGHT_W'(1)) && (col_next >= eff_w);
         end else if (cmd.take_next) begin
            if (a_ff) begin
               a_ff <= 1'b0;
            end else begin
               b_ff <= 1'b0;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      total_ff <= TOTAL_W'(eff_w) * TOTAL_W'(eff_h);
      if (cmd.capture) begin
         kind_ff <= req_data.kind;
         px_ff <= {req_data.red_in, req_data.green_in, req_data.blue_in};
         didx_ff <= 2'd0;
      end
      if (cmd.take_next) begin
         last_ff <= a_ff ? !b_ff : 1'b1;
      end
      if (cmd.drain_start) begin
         last_ff <= 1'b1;
      end
      if (cmd.drain_addr) begin
         dok_ff <= dok_in;
      end
      if (cmd.drain_data) begin
         for (int i = 0; i < 3; i++) begin
            if (didx_ff == 2'(i)) begin
               dnb_ff[i] <= (dok_ff && eff_h >= HEIGHT_W'(2)) ? up_rd : '0;
               dnb_ff[3+i] <= dok_ff ? mid_rd : '0;
               dnb_ff[6+i] <= '0;
            end
         end
         didx_ff <= didx_ff + 2'd1;
      end
      if (cmd.out_load) begin
         rsp_ff <= '{red_out: mags[0], green_out: mags[1], blue_out: mags[2],
                     run_last: last_ff, frame_end: frame_end};
      end
   end

   always_comb begin
      status.ignore = (kind_ff == KIND_DRAIN) ? (row_ff < eff_h) : (row_ff >= eff_h);
      status.is_drain = (kind_ff == KIND_DRAIN);
      status.pending = a_ff | b_ff;
      status.mag_busy = |busy_v;
      status.out_free = !rsp_valid_ff || rsp_ready;
      status.drain_last = (didx_ff == 2'd2);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

>>> src/sem_ctrl.sv
module sem_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  sem_pkg::status_type status,
   output sem_pkg::cmd_type cmd
);
   import sem_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_CHECK = 10'b0000000010,
      S_PADDR = 10'b0000000100,
      S_PCOL  = 10'b0000001000,
      S_PSEL  = 10'b0000010000,
      S_MAG   = 10'b0000100000,
      S_EMIT  = 10'b0001000000,
      S_DADDR = 10'b0010000000,
      S_DDATA = 10'b0100000000,
      S_DMAG  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.ignore) begin
               state_in = S_IDLE;
            end else if (status.is_drain) begin
               state_in = S_DADDR;
            end else begin
               state_in = S_PADDR;
            end
         end
         S_PADDR: begin
            cmd.pix_read = 1'b1;
            state_in = S_PCOL;
         end
         S_PCOL: begin
            cmd.pix_update = 1'b1;
            state_in = S_PSEL;
         end
         S_PSEL: begin
            if (status.pending) begin
               cmd.take_next = 1'b1;
               state_in = S_MAG;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MAG: begin
            if (!status.mag_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (!status.is_drain && status.pending) begin
                  state_in = S_PSEL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DADDR: begin
            cmd.drain_addr = 1'b1;
            state_in = S_DDATA;
         end
         S_DDATA: begin
            cmd.drain_data = 1'b1;
            state_in = status.drain_last ? S_DMAG : S_DADDR;
         end
         S_DMAG: begin
            cmd.drain_start = 1'b1;
            state_in = S_MAG;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

>>> src/sobel_edge_magnitude_rgb.sv
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order, one request at a time.
// Each channel has its own bit-serial square root. A result is produced in three steps:
// selecting the neighbourhood, running the magnitude units and loading the output
// register. A pixel request yields no result, one or two; a drain request reads three
// columns from the single-read-port line stores; an ignored request yields no result.
// Loading a result stalls while the output register is full and not being taken. A result
// waits in the output register while the next request is taken. Writing image_width or
// image_height restarts the frame.
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  sem_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output sem_pkg::rsp_type rsp_data,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [sem_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import sem_pkg::*;

   logic [WIDTH_W-1:0] width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic cfg_write;
   cmd_type cmd;
   status_type status;

   assign pready = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == REG_IMAGE_WIDTH) begin
            width_ff <= pwdata[WIDTH_W-1:0];
         end else begin
            height_ff <= pwdata[HEIGHT_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_IMAGE_WIDTH) ? 32'(width_ff) : 32'(height_ff);

   sem_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .status(status), .cmd(cmd)
   );

   sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .cfg_write(cfg_write), .cfg_width(width_ff), .cfg_height(height_ff),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );
endmodule
